/* rtl/core/tcw_pkg.sv */
// tcw_pkg: shared constants, command codes, state type and the control and
// status bundles of the text console writer
// no dependencies
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // internal widths follow the geometry
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    // fixed port widths
    localparam int IDX_W     = 11;
    localparam int CELL_W    = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int POS_OUT_W = 11;

    // character codes and cell constants
    localparam logic [7:0]        CH_NUL     = 8'h00;
    localparam logic [7:0]        CH_BS      = 8'h08;
    localparam logic [7:0]        CH_TAB     = 8'h09;
    localparam logic [7:0]        CH_LF      = 8'h0A;
    localparam logic [7:0]        CH_CR      = 8'h0D;
    localparam logic [7:0]        CH_SPACE   = 8'h20;
    localparam logic [7:0]        ATTR_RESET = 8'h07;
    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;
    localparam int                TAB_STEP   = 8;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_COLOUR = 2'd2,
        CMD_READ   = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SCROLL,
        ST_RWAIT,
        ST_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic cnt_clr;
        logic cnt_inc;
        logic fill_init;
        logic fill_blank;
        logic scroll;
        logic capture;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_command cmd;
        logic     need_scroll;
        logic     fill_end;
        logic     scroll_end;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/core/text_console_writer.sv */
// text_console_writer: top level of the text-mode console engine
// depends on tcw_pkg, tcw_ctrl, tcw_datapath (and through it tcw_ram)
//
// usage
//   command channel: drive start with the item fields (command, char_code,
//   end_of_text, foreground, background, cell_index); the beat is taken at a
//   rising edge with start high and busy low. busy stays high from the edge
//   after acceptance until the result beat has gone out
//   result channel: o_valid is high for exactly one cycle per item and
//   carries the cell word (reads only, zero otherwise), the cursor after the
//   item and the cursor-update flag. the receiver cannot hold results off
// state sequence of an item, from acceptance to the result beat
//   set colour, plain put: exec, result; read cell: exec, read wait, result
//   put that scrolls: exec, one pass over the cell store (one word read and
//   one written per cycle through separate read and write ports), result
//   clear: exec, one blanking pass (one cell written per cycle), result
//   one item is in flight at a time, so the next beat follows the result
// reset
//   i_rst_n is synchronous, active low. after release a clearing pass writes
//   0x0720 to all COLUMNS*ROWS cells, one per cycle, with busy high; the
//   cursor comes up at 0,0 and the attribute at grey on black
// stalls
//   none on the result side: the result is shown for one cycle only
`default_nettype none

module text_console_writer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_command,
    input  wire logic [7:0]                        i_char_code,
    input  wire logic                              i_end_of_text,
    input  wire logic [3:0]                        i_foreground,
    input  wire logic [3:0]                        i_background,
    input  wire logic [tcw_pkg::IDX_W-1:0]         i_cell_index,
    output logic                                   o_valid,
    output logic      [tcw_pkg::CELL_W-1:0]        o_cell_value,
    output logic      [tcw_pkg::ROW_OUT_W-1:0]     o_cursor_row,
    output logic      [tcw_pkg::COL_OUT_W-1:0]     o_cursor_col,
    output logic      [tcw_pkg::POS_OUT_W-1:0]     o_cursor_position,
    output logic                                   o_cursor_update
);

    // command and status bundles between sequencer and datapath
    tcw_pkg::t_dp_cmd  dp_cmd;
    tcw_pkg::t_dp_stat dp_stat;

    // sequencer: reset clearing pass, item execution, sweeps, result beat
    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // datapath: item latch, cursor and attribute, sweep counter, cell store
    tcw_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_command         (i_command),
        .i_char_code       (i_char_code),
        .i_end_of_text     (i_end_of_text),
        .i_foreground      (i_foreground),
        .i_background      (i_background),
        .i_cell_index      (i_cell_index),
        .o_cell_value      (o_cell_value),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_col      (o_cursor_col),
        .o_cursor_position (o_cursor_position),
        .o_cursor_update   (o_cursor_update)
    );

endmodule

`default_nettype wire

/* rtl/core/tcw_ram.sv */
// tcw_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/tcw_datapath.sv */
// tcw_datapath: command latch, cursor and attribute registers, sweep counter
// and the cell store; depends on tcw_pkg and tcw_ram
`default_nettype none

module tcw_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tcw_pkg::t_dp_cmd                  i_cmd,
    output tcw_pkg::t_dp_stat                      o_stat,
    input  wire logic [1:0]                        i_command,
    input  wire logic [7:0]                        i_char_code,
    input  wire logic                              i_end_of_text,
    input  wire logic [3:0]                        i_foreground,
    input  wire logic [3:0]                        i_background,
    input  wire logic [tcw_pkg::IDX_W-1:0]         i_cell_index,
    output logic      [tcw_pkg::CELL_W-1:0]        o_cell_value,
    output logic      [tcw_pkg::ROW_OUT_W-1:0]     o_cursor_row,
    output logic      [tcw_pkg::COL_OUT_W-1:0]     o_cursor_col,
    output logic      [tcw_pkg::POS_OUT_W-1:0]     o_cursor_position,
    output logic                                   o_cursor_update
);

    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam int CNT_W  = tcw_pkg::CNT_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int CELL_W = tcw_pkg::CELL_W;

    // latched item
    tcw_pkg::t_command           r_cmd;
    logic [7:0]                  r_char;
    logic                        r_eot;
    logic [3:0]                  r_fg;
    logic [3:0]                  r_bg;
    logic [tcw_pkg::IDX_W-1:0]   r_idx;

    // console state
    logic [ROW_W-1:0]            r_row;
    logic [COL_W-1:0]            r_col;
    logic [7:0]                  r_attr;
    logic [CNT_W-1:0]            r_cnt;
    logic [CELL_W-1:0]           r_value;
    logic                        r_update;

    logic [ADDR_W-1:0]           pos_now;
    logic [CELL_W-1:0]           blank;
    logic [COL_W:0]              col_inc;
    logic [COL_W:0]              tab_col;
    logic [CNT_W-1:0]            cnt_m1;
    logic [CNT_W-1:0]            cnt_src;
    logic                        idx_ok;

    // put character decode
    logic [COL_W-1:0]            p_col;
    logic [ROW_W-1:0]            p_row;
    logic                        p_adv;
    logic                        p_we;
    logic [ADDR_W-1:0]           p_addr;
    logic [CELL_W-1:0]           p_data;
    logic                        need_scroll;

    // ram ports
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [CELL_W-1:0]           ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [CELL_W-1:0]           ram_rdata;

    assign pos_now = ADDR_W'(r_row) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(r_col);
    assign blank   = {r_attr, tcw_pkg::CH_SPACE};
    assign col_inc = {1'b0, r_col} + (COL_W+1)'(1);
    assign tab_col = ({1'b0, r_col} + (COL_W+1)'(tcw_pkg::TAB_STEP))
                     & ~((COL_W+1)'(tcw_pkg::TAB_STEP - 1));
    assign cnt_m1  = r_cnt - CNT_W'(1);
    assign cnt_src = r_cnt + CNT_W'(tcw_pkg::COLUMNS);
    assign idx_ok  = (32'(r_idx) < tcw_pkg::CELLS);

    always_comb begin
        p_col  = r_col;
        p_adv  = 1'b0;
        p_we   = 1'b0;
        p_addr = pos_now;
        p_data = {r_attr, r_char};
        case (r_char)
            tcw_pkg::CH_NUL: begin
                p_col = r_col;
            end
            tcw_pkg::CH_LF: begin
                p_col = '0;
                p_adv = 1'b1;
            end
            tcw_pkg::CH_CR: begin
                p_col = '0;
            end
            tcw_pkg::CH_BS: begin
                if (r_col != '0) begin
                    p_col  = r_col - COL_W'(1);
                    p_we   = 1'b1;
                    p_addr = pos_now - ADDR_W'(1);
                    p_data = blank;
                end
            end
            tcw_pkg::CH_TAB: begin
                if (tab_col >= (COL_W+1)'(tcw_pkg::COLUMNS)) begin
                    p_col = '0;
                    p_adv = 1'b1;
                end else begin
                    p_col = tab_col[COL_W-1:0];
                end
            end
            default: begin
                p_we = 1'b1;
                if (col_inc >= (COL_W+1)'(tcw_pkg::COLUMNS)) begin
                    p_col = '0;
                    p_adv = 1'b1;
                end else begin
                    p_col = col_inc[COL_W-1:0];
                end
            end
        endcase
    end

    // passing the last row keeps the cursor there and scrolls instead
    assign need_scroll = p_adv && (r_row == ROW_W'(tcw_pkg::ROWS - 1));
    assign p_row       = (p_adv && !need_scroll) ? r_row + ROW_W'(1) : r_row;

    // single write port shared by sweeps and single-cell writes
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = p_addr;
        ram_wdata = p_data;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(r_idx);
        if (i_cmd.fill_init || i_cmd.fill_blank) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt[ADDR_W-1:0];
            ram_wdata = i_cmd.fill_init ? tcw_pkg::CELL_RESET : blank;
        end else if (i_cmd.scroll) begin
            // read one row ahead, write the registered word one row up in the next cycle
            ram_we    = (r_cnt != '0);
            ram_waddr = cnt_m1[ADDR_W-1:0];
            ram_wdata = (cnt_m1 < CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS))
                        ? ram_rdata : blank;
            ram_re    = (r_cnt < CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS));
            ram_raddr = cnt_src[ADDR_W-1:0];
        end else if (i_cmd.exec) begin
            if (r_cmd == tcw_pkg::CMD_PUT) begin
                ram_we = p_we;
            end
            if (r_cmd == tcw_pkg::CMD_READ) begin
                ram_re = idx_ok;
            end
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_cell_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= tcw_pkg::t_command'(i_command);
            r_char <= i_char_code;
            r_eot  <= i_end_of_text;
            r_fg   <= i_foreground;
            r_bg   <= i_background;
            r_idx  <= i_cell_index;
        end
        if (i_cmd.exec) begin
            r_value <= '0;
            case (r_cmd)
                tcw_pkg::CMD_PUT:   r_update <= r_eot;
                tcw_pkg::CMD_CLEAR: r_update <= 1'b1;
                default:            r_update <= 1'b0;
            endcase
        end
        if (i_cmd.capture) begin
            r_value <= idx_ok ? ram_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_attr <= tcw_pkg::ATTR_RESET;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.exec) begin
                case (r_cmd)
                    tcw_pkg::CMD_PUT: begin
                        r_row <= p_row;
                        r_col <= p_col;
                    end
                    tcw_pkg::CMD_CLEAR: begin
                        r_row <= '0;
                        r_col <= '0;
                    end
                    tcw_pkg::CMD_COLOUR: begin
                        r_attr <= {r_bg, r_fg};
                    end
                    default: begin
                        r_attr <= r_attr;
                    end
                endcase
            end
        end
    end

    assign o_stat.cmd         = r_cmd;
    assign o_stat.need_scroll = need_scroll;
    assign o_stat.fill_end    = (r_cnt == CNT_W'(tcw_pkg::CELLS - 1));
    assign o_stat.scroll_end  = (r_cnt == CNT_W'(tcw_pkg::CELLS));

    assign o_cell_value      = r_value;
    assign o_cursor_row      = tcw_pkg::ROW_OUT_W'(r_row);
    assign o_cursor_col      = tcw_pkg::COL_OUT_W'(r_col);
    assign o_cursor_position = tcw_pkg::POS_OUT_W'(pos_now);
    assign o_cursor_update   = r_update;

endmodule

`default_nettype wire

/* rtl/core/tcw_ctrl.sv */
// tcw_ctrl: sequencing state machine of the text console writer
// depends on tcw_pkg
`default_nettype none

module tcw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    output logic                   o_valid,
    output tcw_pkg::t_dp_cmd       o_cmd,
    input  wire tcw_pkg::t_dp_stat i_stat
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            tcw_pkg::ST_INIT: begin
                o_cmd.fill_init = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_stat.fill_end) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                o_cmd.exec    = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                case (i_stat.cmd)
                    tcw_pkg::CMD_PUT: begin
                        n_state = i_stat.need_scroll ? tcw_pkg::ST_SCROLL
                                                     : tcw_pkg::ST_RESP;
                    end
                    tcw_pkg::CMD_CLEAR: n_state = tcw_pkg::ST_FILL;
                    tcw_pkg::CMD_READ:  n_state = tcw_pkg::ST_RWAIT;
                    default:            n_state = tcw_pkg::ST_RESP;
                endcase
            end
            tcw_pkg::ST_FILL: begin
                o_cmd.fill_blank = 1'b1;
                o_cmd.cnt_inc    = 1'b1;
                if (i_stat.fill_end) begin
                    n_state = tcw_pkg::ST_RESP;
                end
            end
            tcw_pkg::ST_SCROLL: begin
                o_cmd.scroll  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.scroll_end) begin
                    n_state = tcw_pkg::ST_RESP;
                end
            end
            tcw_pkg::ST_RWAIT: begin
                o_cmd.capture = 1'b1;
                n_state       = tcw_pkg::ST_RESP;
            end
            tcw_pkg::ST_RESP: begin
                o_valid = 1'b1;
                n_state = tcw_pkg::ST_IDLE;
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/tcw_checker.sv */
// tcw_checker: port-level checks of the text console writer, bound to the top
// depends on tcw_pkg and text_console_writer
`default_nettype none

module tcw_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              o_valid,
    input wire logic [tcw_pkg::ROW_OUT_W-1:0]     o_cursor_row,
    input wire logic [tcw_pkg::COL_OUT_W-1:0]     o_cursor_col,
    input wire logic [tcw_pkg::POS_OUT_W-1:0]     o_cursor_position
);

    // a result beat only ever closes an item in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat while not busy");

    // an accepted beat locks out the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_cursor_row) < tcw_pkg::ROWS)
                 && (32'(o_cursor_col) < tcw_pkg::COLUMNS))
        else $error("cursor off screen");

    // linear position is row and column folded into the port width
    a_cursor_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cursor_position
            == tcw_pkg::POS_OUT_W'(32'(o_cursor_row) * tcw_pkg::COLUMNS
                                   + 32'(o_cursor_col)))
        else $error("linear cursor disagrees with row and column");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
